// ===== rtl/cwfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the checked word frame receiver.
// No dependencies; imported by every module under rtl/.
package cwfr_pkg;

  localparam int unsigned WORD_COUNT_DEF = 8;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  PREAMBLE_RESET = 8'h10;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_PREAMBLE = 2'd1,
    ST_CHECK    = 2'd2
  } cwfr_status_e;

  // end-of-frame event from the byte parser to the result sequencer
  typedef struct packed {
    logic         valid;
    cwfr_status_e status;
    logic         bank;
  } cwfr_frame_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] cwfr_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc_checked_word_frame_receiver.sv =====
// Top level of the CRC-16 checked word frame receiver: byte parser, two-bank word store
// and result sequencer. Depends on cwfr_pkg, cwfr_parser, cwfr_word_mem, cwfr_burst.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata[7:0] data_byte; tuser frame_start
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata word_index, word_value; tuser status;
//                                               tlast last_result
//  cfg      in   cfg_we_i                       cfg_wdata_i expected_preamble
//
// One byte per cycle on the input while s_axis_tready is high. A good frame gives WORD_COUNT
// results at one per cycle while the output is not stalled; an error frame gives one result.
// Words are read from the store bank of the finished frame while the next frame fills the
// other bank; the last byte of a frame waits until the previous frame's results are issued.
// Output stalls back up through a two-entry buffer. Reset is immediate, no clearing pass.
module crc_checked_word_frame_receiver #(
  parameter int unsigned WORD_COUNT = cwfr_pkg::WORD_COUNT_DEF,
  parameter int unsigned IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
  parameter int unsigned TDATA_W    = ((IDX_W + 16 + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tuser,   // [0] frame_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // word_index, then word_value, zero pad
  output logic [1:0]         m_axis_tuser,   // [1:0] frame_status
  output logic               m_axis_tlast
);
  import cwfr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2 * WORD_COUNT);

  cwfr_frame_t       frame;
  logic              busy;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, mem_rdata;

  cwfr_parser #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .busy_i        (busy),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .frame_o       (frame)
  );

  cwfr_word_mem #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cwfr_burst #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (ADDR_W),
    .IDX_W      (IDX_W),
    .TDATA_W    (TDATA_W)
  ) u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .busy_o        (busy),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/cwfr_word_mem.sv =====
// Two-bank word store: one write port, one read port, registered read data.
// Uses cwfr_pkg for the default word count.
module cwfr_word_mem #(
  parameter int unsigned WORD_COUNT = cwfr_pkg::WORD_COUNT_DEF,
  parameter int unsigned ADDR_W     = $clog2(2 * WORD_COUNT)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);
  import cwfr_pkg::*;

  localparam int unsigned DEPTH = 2 * WORD_COUNT;

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cwfr_parser.sv =====
// Byte parser: frame position, CRC, preamble and check bytes, word writes to the store.
// Uses cwfr_pkg (CRC function, status codes, frame event struct).
module cwfr_parser #(
  parameter int unsigned WORD_COUNT = cwfr_pkg::WORD_COUNT_DEF,
  parameter int unsigned ADDR_W     = $clog2(2 * WORD_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  busy_i,
  output logic                  mem_we_o,
  output logic [ADDR_W-1:0]     mem_waddr_o,
  output logic [15:0]           mem_wdata_o,
  output cwfr_pkg::cwfr_frame_t frame_o
);
  import cwfr_pkg::*;

  localparam int unsigned FRAME_BYTES = 2 * WORD_COUNT + 4;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned IDX_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [POS_W-1:0] POS_PRE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CHK  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic             pbad_q, pbad_d;
  logic [7:0]       chk_q, chk_d;
  logic [7:0]       hi_q, hi_d;
  logic             bank_q, bank_d;
  logic [7:0]       pre_q, pre_d;

  logic             accept;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] k;
  logic [IDX_W-1:0] widx;

  // last byte waits while the previous frame's results are still going out
  assign s_axis_tready = !(pos_q == POS_LAST && busy_i);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos           = s_axis_tuser ? '0 : pos_q;
  assign k             = pos - POS_W'(2);
  assign widx          = IDX_W'(k >> 1);

  assign mem_waddr_o = ADDR_W'(widx) + (bank_q ? ADDR_W'(WORD_COUNT) : '0);
  assign mem_wdata_o = {hi_q, s_axis_tdata};

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    pbad_d   = pbad_q;
    chk_d    = chk_q;
    hi_d     = hi_q;
    bank_d   = bank_q;
    pre_d    = pre_q;
    mem_we_o = 1'b0;
    frame_o  = '0;
    if (cfg_we_i) begin
      pre_d = cfg_wdata_i;
    end
    if (accept) begin
      pos_d = (pos == POS_LAST) ? '0 : pos + POS_W'(1);
      if (pos == '0) begin
        crc_d  = CRC_INIT;
        pbad_d = 1'b0;
        chk_d  = '0;
      end else if (pos == POS_PRE) begin
        pbad_d = (s_axis_tdata != pre_q);
      end else if (pos < POS_CHK) begin
        if (!k[0]) begin
          hi_d = s_axis_tdata;
        end else begin
          mem_we_o = 1'b1;
        end
        crc_d = cwfr_crc_byte(crc_q, s_axis_tdata);
      end else if (pos == POS_CHK) begin
        chk_d = s_axis_tdata;
      end else begin
        frame_o.valid = 1'b1;
        frame_o.bank  = bank_q;
        if (pbad_q) begin
          frame_o.status = ST_PREAMBLE;
        end else if ({crc_q[7:0], crc_q[15:8]} != {chk_q, s_axis_tdata}) begin
          frame_o.status = ST_CHECK;
        end else begin
          frame_o.status = ST_GOOD;
          bank_d         = ~bank_q;  // good frame: its bank is now owned by the sequencer
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CRC_INIT;
      pbad_q <= 1'b0;
      chk_q  <= '0;
      bank_q <= 1'b0;
      pre_q  <= PREAMBLE_RESET;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      pbad_q <= pbad_d;
      chk_q  <= chk_d;
      bank_q <= bank_d;
      pre_q  <= pre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
  end

endmodule

// ===== rtl/cwfr_burst.sv =====
// Result sequencer: reads a finished frame's words from the store and queues results
// in a two-entry output buffer. Uses cwfr_pkg (status codes, frame event struct).
module cwfr_burst #(
  parameter int unsigned WORD_COUNT = cwfr_pkg::WORD_COUNT_DEF,
  parameter int unsigned ADDR_W     = $clog2(2 * WORD_COUNT),
  parameter int unsigned IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
  parameter int unsigned TDATA_W    = ((IDX_W + 16 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cwfr_pkg::cwfr_frame_t frame_i,
  output logic                  busy_o,
  output logic                  mem_re_o,
  output logic [ADDR_W-1:0]     mem_raddr_o,
  input  logic [15:0]           mem_rdata_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);
  import cwfr_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORD_COUNT - 1);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [15:0]      value;
    cwfr_status_e     status;
    logic             last;
  } res_t;

  logic             act_q;
  cwfr_status_e     st_q;
  logic             bank_q;
  logic [IDX_W-1:0] idx_q;

  logic             pend_q;
  res_t             pend_res_q;

  res_t             fifo_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  logic             pop, issue, issue_last;
  logic [1:0]       occ;
  res_t             push_res;

  assign pop        = m_axis_tvalid && m_axis_tready;
  assign occ        = cnt_q + {1'b0, pend_q};
  assign issue      = act_q && (occ < 2'd2 || (occ == 2'd2 && pop));
  assign issue_last = (st_q != ST_GOOD) || (idx_q == IDX_LAST);

  assign busy_o      = act_q;
  assign mem_re_o    = issue && (st_q == ST_GOOD);
  assign mem_raddr_o = ADDR_W'(idx_q) + (bank_q ? ADDR_W'(WORD_COUNT) : '0);

  always_comb begin
    push_res       = pend_res_q;
    push_res.value = (pend_res_q.status == ST_GOOD) ? mem_rdata_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      st_q   <= ST_GOOD;
      bank_q <= 1'b0;
      idx_q  <= '0;
      pend_q <= 1'b0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= issue;
      if (frame_i.valid) begin
        act_q  <= 1'b1;
        st_q   <= frame_i.status;
        bank_q <= frame_i.bank;
        idx_q  <= '0;
      end else if (issue) begin
        if (issue_last) begin
          act_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      if (pend_q) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, pend_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_res_q.idx    <= (st_q == ST_GOOD) ? idx_q : '0;
      pend_res_q.value  <= '0;
      pend_res_q.status <= st_q;
      pend_res_q.last   <= issue_last;
    end
    if (pend_q) begin
      fifo_q[wptr_q] <= push_res;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = TDATA_W'({fifo_q[rptr_q].value, fifo_q[rptr_q].idx});
  assign m_axis_tuser  = fifo_q[rptr_q].status;
  assign m_axis_tlast  = fifo_q[rptr_q].last;

  a_no_frame_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid |-> !act_q)
    else $error("frame event while sequencer busy");

  a_buffer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + {1'b0, pend_q}) <= 2'd2)
    else $error("output buffer overrun");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && issue_last |=> !act_q || $past(frame_i.valid))
    else $error("burst continues after last result");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && (st_q != ST_GOOD) |-> issue_last && !mem_re_o)
    else $error("error result must be single and read nothing");

endmodule
